/* src/toy_alu_store_pipeline_unit_defines.svh */
// Assertion macros for the toy ALU/store pipeline unit.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef TOY_ALU_STORE_PIPELINE_UNIT_DEFINES_SVH
`define TOY_ALU_STORE_PIPELINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define TASP_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");

`define TASP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

`define TASP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define TASP_ASSERT_ALWAYS(label, clk, rst, cond)
`define TASP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TASP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/tasp_pkg.sv */
// Shared widths, command and opcode codes, and stage types for the toy ALU/store pipeline.
// Used by the channel interfaces and the top level; depends on nothing.
package tasp_pkg;

   localparam int DATA_W     = 8;
   localparam int CMD_W      = 3;
   localparam int OP_W       = 2;
   localparam int REG_IDX_W  = 4;
   localparam int NUM_REGS   = 16;
   localparam int MEM_ADDR_W = 4;
   localparam int MEM_WORDS  = 16;

   localparam int RQ_DEPTH_DEFAULT = 4;

   localparam logic [DATA_W-1:0] REG_RESET_VALUE = 8'hFF;
   localparam logic [DATA_W-1:0] MEM_RESET_VALUE = 8'hFF;

   localparam logic [CMD_W-1:0] CMD_STEP     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_BUBBLE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_REG = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOAD_MEM = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_REG = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ_MEM = 3'd5;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_ST  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic                 valid;
      opcode_type           op;
      logic [REG_IDX_W-1:0] rd;
      logic [DATA_W-1:0]    a;
      logic [DATA_W-1:0]    b;
   } stage_type;

   typedef struct packed {
      logic                 valid;
      logic [REG_IDX_W-1:0] rd;
      logic [DATA_W-1:0]    a;
      logic [DATA_W-1:0]    b;
   } pp_stage_type;

   typedef struct packed {
      logic                  valid;
      logic [REG_IDX_W-1:0]  rd;
      logic [MEM_ADDR_W-1:0] word;
   } addr_stage_type;

   typedef struct packed {
      logic                  reg_write_valid;
      logic [REG_IDX_W-1:0]  reg_write_index;
      logic [DATA_W-1:0]     reg_write_value;
      logic                  mem_write_valid;
      logic [MEM_ADDR_W-1:0] mem_write_addr;
      logic [DATA_W-1:0]     mem_write_value;
      logic                  pipeline_idle;
      logic                  read_written;
      logic [DATA_W-1:0]     read_value;
      logic                  queue_overflow;
   } rsp_type;

endpackage

/* src/tasp_if.sv */
// Request and response channel interfaces (valid/ready) of the toy ALU/store pipeline.
// Depends on tasp_pkg for field widths.
interface tasp_req_if import tasp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic [OP_W-1:0]       opcode;
   logic [REG_IDX_W-1:0]  dest_reg;
   logic [REG_IDX_W-1:0]  src_a_reg;
   logic [REG_IDX_W-1:0]  src_b_reg;
   logic [DATA_W-1:0]     store_offset;
   logic [REG_IDX_W-1:0]  target_index;
   logic [DATA_W-1:0]     load_value;

   modport source (output valid, cmd, opcode, dest_reg, src_a_reg, src_b_reg,
                   store_offset, target_index, load_value,
                   input ready);
   modport sink (input valid, cmd, opcode, dest_reg, src_a_reg, src_b_reg,
                 store_offset, target_index, load_value,
                 output ready);
endinterface

interface tasp_rsp_if import tasp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  reg_write_valid;
   logic [REG_IDX_W-1:0]  reg_write_index;
   logic [DATA_W-1:0]     reg_write_value;
   logic                  mem_write_valid;
   logic [MEM_ADDR_W-1:0] mem_write_addr;
   logic [DATA_W-1:0]     mem_write_value;
   logic                  pipeline_idle;
   logic                  read_written;
   logic [DATA_W-1:0]     read_value;
   logic                  queue_overflow;

   modport source (output valid, reg_write_valid, reg_write_index, reg_write_value,
                   mem_write_valid, mem_write_addr, mem_write_value, pipeline_idle,
                   read_written, read_value, queue_overflow,
                   input ready);
   modport sink (input valid, reg_write_valid, reg_write_index, reg_write_value,
                 mem_write_valid, mem_write_addr, mem_write_value, pipeline_idle,
                 read_written, read_value, queue_overflow,
                 output ready);
endinterface

/* src/toy_alu_store_pipeline_unit.sv */
// Top level of the toy ALU/store pipeline: register file, data memory, stage registers,
// result queue and response register. Depends on tasp_pkg, tasp_if and the defines header.
//
// Usage:
//   req_bus carries one command beat: a pipeline step (with or without a new
//   instruction), a register or memory load, or a register or memory read.
//   rsp_bus returns exactly one beat per request beat, in order.
//   The response of a beat is registered and valid in the cycle after the beat
//   is accepted. Throughput is one beat per cycle; the whole step (writeback,
//   multiply, ALU, store, decode with register reads) is done by the logic
//   between the state registers and the response register, and its longest
//   path is the 8x8 multiply of the partial-product stage into the result queue.
//   req_bus.ready is high while the response register is empty or being taken,
//   so a new beat enters in the same cycle the previous response leaves.
//   When rsp_bus.ready is low the response holds and req_bus.ready drops until
//   the response is taken; no state changes meanwhile.
//   Synchronous reset clears all stage valid bits, the result queue pointers and
//   count, and the written flags of the register file and data memory; unwritten
//   entries read as 255. No clearing pass is needed after reset.
`include "toy_alu_store_pipeline_unit_defines.svh"

module toy_alu_store_pipeline_unit import tasp_pkg::*; #(
   parameter int RQ_DEPTH = RQ_DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   tasp_req_if.sink   req_bus,
   tasp_rsp_if.source rsp_bus
);

   localparam int PtrW = $clog2(RQ_DEPTH);
   localparam int CntW = $clog2(RQ_DEPTH + 1);
   localparam logic [CntW-1:0] RqFull  = CntW'(RQ_DEPTH);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(RQ_DEPTH - 1);

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      return (p == PtrLast) ? '0 : p + PtrW'(1);
   endfunction

   // Bypass the same-step writeback, else stored value, else reset value.
   function automatic logic [DATA_W-1:0] rf_pick(input logic hit,
                                                 input logic [DATA_W-1:0] byp,
                                                 input logic written,
                                                 input logic [DATA_W-1:0] stored);
      return hit ? byp : (written ? stored : REG_RESET_VALUE);
   endfunction

   // Register file and data memory with written flags.
   logic [DATA_W-1:0]    reg_val_ff [NUM_REGS];
   logic [NUM_REGS-1:0]  reg_wr_ff;
   logic [DATA_W-1:0]    mem_val_ff [MEM_WORDS];
   logic [MEM_WORDS-1:0] mem_wr_ff;

   logic                  rf_we;
   logic [REG_IDX_W-1:0]  rf_widx;
   logic [DATA_W-1:0]     rf_wdata;
   logic                  dm_we;
   logic [MEM_ADDR_W-1:0] dm_waddr;
   logic [DATA_W-1:0]     dm_wdata;

   // Pipeline stages.
   stage_type      dec_ff,   dec_in;
   stage_type      arith_ff, arith_in;
   stage_type      store_ff, store_in;
   pp_stage_type   pp_ff,    pp_in;
   addr_stage_type addr_ff,  addr_in;

   // Result queue.
   logic [REG_IDX_W-1:0] rq_rd_ff  [RQ_DEPTH];
   logic [DATA_W-1:0]    rq_val_ff [RQ_DEPTH];
   logic [PtrW-1:0]      rq_head_ff,  rq_head_in;
   logic [PtrW-1:0]      rq_tail_ff,  rq_tail_in;
   logic [CntW-1:0]      rq_count_ff, rq_count_in;

   logic                 q1_we, q2_we;
   logic [PtrW-1:0]      q1_slot, q2_slot;
   logic [REG_IDX_W-1:0] q1_rd, q2_rd;
   logic [DATA_W-1:0]    q1_val, q2_val;

   // Response register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic req_fire;
   logic step_cmd;

   logic                 wb_do;
   logic [REG_IDX_W-1:0] wb_rd;
   logic [DATA_W-1:0]    wb_val;
   logic [2*DATA_W-1:0]  pp_prod;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign step_cmd      = (req_bus.cmd == CMD_STEP) || (req_bus.cmd == CMD_BUBBLE);

   assign wb_do   = (rq_count_ff != '0);
   assign wb_rd   = rq_rd_ff[rq_head_ff];
   assign wb_val  = rq_val_ff[rq_head_ff];
   assign pp_prod = pp_ff.a * pp_ff.b;

   always_comb begin
      logic [CntW-1:0]   cnt1;
      logic [CntW-1:0]   cnt2;
      logic [PtrW-1:0]   tail1;
      logic              push1_ok;
      logic              push2_req;
      logic              push2_ok;
      logic [DATA_W-1:0] alu_res;
      opcode_type        new_op;

      dec_in      = dec_ff;
      arith_in    = arith_ff;
      store_in    = store_ff;
      pp_in       = pp_ff;
      addr_in     = addr_ff;
      rq_head_in  = rq_head_ff;
      rq_tail_in  = rq_tail_ff;
      rq_count_in = rq_count_ff;
      rsp_in      = '0;
      rf_we       = 1'b0;
      rf_widx     = req_bus.target_index;
      rf_wdata    = req_bus.load_value;
      dm_we       = 1'b0;
      dm_waddr    = req_bus.target_index;
      dm_wdata    = req_bus.load_value;
      q1_we       = 1'b0;
      q1_slot     = rq_tail_ff;
      q1_rd       = pp_ff.rd;
      q1_val      = pp_prod[DATA_W-1:0];
      q2_we       = 1'b0;
      q2_slot     = rq_tail_ff;
      q2_rd       = arith_ff.rd;
      alu_res     = (arith_ff.op == OP_SUB) ? arith_ff.a - arith_ff.b
                                            : arith_ff.a + arith_ff.b;
      q2_val      = alu_res;
      cnt1        = rq_count_ff;
      cnt2        = rq_count_ff;
      tail1       = rq_tail_ff;
      push1_ok    = 1'b0;
      push2_req   = 1'b0;
      push2_ok    = 1'b0;
      new_op      = opcode_type'(req_bus.opcode);

      if (req_fire) begin
         unique case (req_bus.cmd)
            CMD_STEP, CMD_BUBBLE: begin
               // Writeback of the queue head.
               if (wb_do) begin
                  rf_we                  = 1'b1;
                  rf_widx                = wb_rd;
                  rf_wdata               = wb_val;
                  rsp_in.reg_write_valid = 1'b1;
                  rsp_in.reg_write_index = wb_rd;
                  rsp_in.reg_write_value = wb_val;
                  rq_head_in             = ptr_next(rq_head_ff);
               end
               cnt1 = rq_count_ff - CntW'(wb_do);

               // Multiply finishes, then ALU result; each push checked in turn.
               push1_ok = pp_ff.valid && (cnt1 != RqFull);
               q1_we    = push1_ok;
               q1_slot  = rq_tail_ff;
               tail1    = push1_ok ? ptr_next(rq_tail_ff) : rq_tail_ff;
               cnt2     = cnt1 + CntW'(push1_ok);

               push2_req = arith_ff.valid && (arith_ff.op != OP_MUL);
               push2_ok  = push2_req && (cnt2 != RqFull);
               q2_we     = push2_ok;
               q2_slot   = tail1;
               rq_tail_in  = push2_ok ? ptr_next(tail1) : tail1;
               rq_count_in = cnt2 + CntW'(push2_ok);

               rsp_in.queue_overflow = (pp_ff.valid && !push1_ok) || (push2_req && !push2_ok);

               pp_in       = '0;
               if (arith_ff.valid && (arith_ff.op == OP_MUL)) begin
                  pp_in.valid = 1'b1;
                  pp_in.rd    = arith_ff.rd;
                  pp_in.a     = arith_ff.a;
                  pp_in.b     = arith_ff.b;
               end

               // Store: data register read after this step's writeback.
               if (addr_ff.valid) begin
                  dm_we    = 1'b1;
                  dm_waddr = addr_ff.word;
                  dm_wdata = rf_pick(wb_do && (wb_rd == addr_ff.rd), wb_val,
                                     reg_wr_ff[addr_ff.rd], reg_val_ff[addr_ff.rd]);
                  rsp_in.mem_write_valid = 1'b1;
                  rsp_in.mem_write_addr  = addr_ff.word;
                  rsp_in.mem_write_value = dm_wdata;
               end

               addr_in.valid = store_ff.valid;
               if (store_ff.valid) begin
                  addr_in.rd   = store_ff.rd;
                  addr_in.word = MEM_ADDR_W'(store_ff.a + store_ff.b);
               end

               arith_in.valid = 1'b0;
               store_in.valid = 1'b0;
               if (dec_ff.valid) begin
                  if (dec_ff.op == OP_ST) begin
                     store_in = dec_ff;
                  end else begin
                     arith_in = dec_ff;
                  end
               end

               dec_in = '0;
               if (req_bus.cmd == CMD_STEP) begin
                  dec_in.valid = 1'b1;
                  dec_in.op    = new_op;
                  dec_in.rd    = req_bus.dest_reg;
                  dec_in.a     = rf_pick(wb_do && (wb_rd == req_bus.src_a_reg), wb_val,
                                         reg_wr_ff[req_bus.src_a_reg],
                                         reg_val_ff[req_bus.src_a_reg]);
                  dec_in.b     = (new_op == OP_ST) ? req_bus.store_offset
                               : rf_pick(wb_do && (wb_rd == req_bus.src_b_reg), wb_val,
                                         reg_wr_ff[req_bus.src_b_reg],
                                         reg_val_ff[req_bus.src_b_reg]);
               end
            end
            CMD_LOAD_REG: begin
               rf_we = 1'b1;
            end
            CMD_LOAD_MEM: begin
               dm_we = 1'b1;
            end
            CMD_READ_REG: begin
               rsp_in.read_written = reg_wr_ff[req_bus.target_index];
               rsp_in.read_value   = rf_pick(1'b0, REG_RESET_VALUE,
                                             reg_wr_ff[req_bus.target_index],
                                             reg_val_ff[req_bus.target_index]);
            end
            CMD_READ_MEM: begin
               rsp_in.read_written = mem_wr_ff[req_bus.target_index];
               rsp_in.read_value   = mem_wr_ff[req_bus.target_index]
                                   ? mem_val_ff[req_bus.target_index] : MEM_RESET_VALUE;
            end
            default: begin
               // Unknown command: no state change.
            end
         endcase
      end

      rsp_in.pipeline_idle = !dec_in.valid && !arith_in.valid && !store_in.valid &&
                             !pp_in.valid && !addr_in.valid && (rq_count_in == '0);

      // Hold the response until taken; load a new one on each accepted beat.
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff       <= '0;
         arith_ff     <= '0;
         store_ff     <= '0;
         pp_ff        <= '0;
         addr_ff      <= '0;
         rq_head_ff   <= '0;
         rq_tail_ff   <= '0;
         rq_count_ff  <= '0;
         reg_wr_ff    <= '0;
         mem_wr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dec_ff       <= dec_in;
         arith_ff     <= arith_in;
         store_ff     <= store_in;
         pp_ff        <= pp_in;
         addr_ff      <= addr_in;
         rq_head_ff   <= rq_head_in;
         rq_tail_ff   <= rq_tail_in;
         rq_count_ff  <= rq_count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rf_we) begin
            reg_wr_ff[rf_widx] <= 1'b1;
         end
         if (dm_we) begin
            mem_wr_ff[dm_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         reg_val_ff[rf_widx] <= rf_wdata;
      end
      if (dm_we) begin
         mem_val_ff[dm_waddr] <= dm_wdata;
      end
      if (q1_we) begin
         rq_rd_ff[q1_slot]  <= q1_rd;
         rq_val_ff[q1_slot] <= q1_val;
      end
      if (q2_we) begin
         rq_rd_ff[q2_slot]  <= q2_rd;
         rq_val_ff[q2_slot] <= q2_val;
      end
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.reg_write_valid = rsp_ff.reg_write_valid;
   assign rsp_bus.reg_write_index = rsp_ff.reg_write_index;
   assign rsp_bus.reg_write_value = rsp_ff.reg_write_value;
   assign rsp_bus.mem_write_valid = rsp_ff.mem_write_valid;
   assign rsp_bus.mem_write_addr  = rsp_ff.mem_write_addr;
   assign rsp_bus.mem_write_value = rsp_ff.mem_write_value;
   assign rsp_bus.pipeline_idle   = rsp_ff.pipeline_idle;
   assign rsp_bus.read_written    = rsp_ff.read_written;
   assign rsp_bus.read_value      = rsp_ff.read_value;
   assign rsp_bus.queue_overflow  = rsp_ff.queue_overflow;

   `TASP_ASSERT_ALWAYS(a_rq_count_max, clock, reset, rq_count_ff <= RqFull)
   `TASP_ASSERT_ALWAYS(a_rq_tail_track, clock, reset, (int'(rq_head_ff) + int'(rq_count_ff) == int'(rq_tail_ff)) || (int'(rq_head_ff) + int'(rq_count_ff) == int'(rq_tail_ff) + RQ_DEPTH))
   `TASP_ASSERT_NEXT(a_ovf_leaves_full, clock, reset, req_fire && rsp_in.queue_overflow, rq_count_ff == RqFull)
   `TASP_ASSERT_NEXT(a_store_reported, clock, reset, req_fire && step_cmd && addr_ff.valid, rsp_valid_ff && rsp_ff.mem_write_valid)

endmodule

/* verif/toy_alu_store_pipeline_unit_tb.sv */
// Self-checking testbench for the toy ALU/store pipeline unit: directed and random command beats.
// Predicts every response beat in order and checks it field by field.
// Depends on tasp_pkg, tasp_req_if/tasp_rsp_if and the toy_alu_store_pipeline_unit top level.
module toy_alu_store_pipeline_unit_tb import tasp_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0] CMD_RESERVED_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RESERVED_B = 3'd7;
   localparam int RANDOM_PER_PHASE = 131;
   localparam int NUM_PHASES       = 4;
   localparam int STALL_LIMIT      = 2000;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [OP_W-1:0]      opcode;
      logic [REG_IDX_W-1:0] dest_reg;
      logic [REG_IDX_W-1:0] src_a_reg;
      logic [REG_IDX_W-1:0] src_b_reg;
      logic [DATA_W-1:0]    store_offset;
      logic [REG_IDX_W-1:0] target_index;
      logic [DATA_W-1:0]    load_value;
   } cmd_beat_type;

   typedef struct packed {
      logic [REG_IDX_W-1:0] rd;
      logic [DATA_W-1:0]    value;
   } writeback_type;

   logic clock = 1'b0;
   logic reset;

   tasp_req_if req_bus ();
   tasp_rsp_if rsp_bus ();

   toy_alu_store_pipeline_unit #(
      .RQ_DEPTH(RQ_DEPTH_DEFAULT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the pipeline state
   logic [DATA_W-1:0] shadow_regs [NUM_REGS];
   logic              shadow_reg_written [NUM_REGS];
   logic [DATA_W-1:0] shadow_mem [MEM_WORDS];
   logic              shadow_mem_written [MEM_WORDS];
   stage_type         shadow_decode;
   stage_type         shadow_arith;
   stage_type         shadow_store;
   pp_stage_type      shadow_pp;
   addr_stage_type    shadow_addr;
   writeback_type     shadow_wb_q [$];

   cmd_beat_type pending_beats [$];
   rsp_type      expected_rsp_q [$];

   int queued_count   = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   function automatic cmd_beat_type make_beat(logic [CMD_W-1:0] cmd, opcode_type op,
                                              int rd, int ra, int rb, int offset,
                                              int idx, int value);
      cmd_beat_type b;
      b.cmd          = cmd;
      b.opcode       = op;
      b.dest_reg     = REG_IDX_W'(rd);
      b.src_a_reg    = REG_IDX_W'(ra);
      b.src_b_reg    = REG_IDX_W'(rb);
      b.store_offset = DATA_W'(offset);
      b.target_index = REG_IDX_W'(idx);
      b.load_value   = DATA_W'(value);
      return b;
   endfunction

   task automatic queue_beat(cmd_beat_type b);
      pending_beats = {pending_beats, b};
   endtask

   // Returns 1 when the result fits in the writeback queue, 0 when it is dropped.
   function automatic logic enqueue_writeback(logic [REG_IDX_W-1:0] rd,
                                              logic [DATA_W-1:0] value);
      writeback_type e;
      if (shadow_wb_q.size() >= RQ_DEPTH_DEFAULT) return 1'b0;
      e.rd        = rd;
      e.value     = value;
      shadow_wb_q = {shadow_wb_q, e};
      return 1'b1;
   endfunction

   function automatic rsp_type predict_response(cmd_beat_type b);
      rsp_type           r;
      stage_type         nd;
      writeback_type     wb;
      logic              ovf;
      logic [DATA_W-1:0] alu;
      logic [DATA_W-1:0] addr_sum;
      r = '0;
      case (b.cmd)
         CMD_STEP, CMD_BUBBLE: begin
            ovf = 1'b0;
            // writeback of the queue head
            if (shadow_wb_q.size() != 0) begin
               wb = shadow_wb_q[0];
               shadow_wb_q.delete(0);
               shadow_regs[wb.rd]        = wb.value;
               shadow_reg_written[wb.rd] = 1'b1;
               r.reg_write_valid = 1'b1;
               r.reg_write_index = wb.rd;
               r.reg_write_value = wb.value;
            end
            // multiply completes
            if (shadow_pp.valid) begin
               alu = shadow_pp.a * shadow_pp.b;
               if (!enqueue_writeback(shadow_pp.rd, alu)) ovf = 1'b1;
            end
            shadow_pp.valid = 1'b0;
            if (shadow_arith.valid) begin
               if (shadow_arith.op == OP_MUL) begin
                  shadow_pp.valid = 1'b1;
                  shadow_pp.rd    = shadow_arith.rd;
                  shadow_pp.a     = shadow_arith.a;
                  shadow_pp.b     = shadow_arith.b;
               end else begin
                  alu = (shadow_arith.op == OP_SUB) ? shadow_arith.a - shadow_arith.b
                                                    : shadow_arith.a + shadow_arith.b;
                  if (!enqueue_writeback(shadow_arith.rd, alu)) ovf = 1'b1;
               end
            end
            // store reads its data register after this step's writeback
            if (shadow_addr.valid) begin
               shadow_mem[shadow_addr.word]         = shadow_regs[shadow_addr.rd];
               shadow_mem_written[shadow_addr.word] = 1'b1;
               r.mem_write_valid = 1'b1;
               r.mem_write_addr  = shadow_addr.word;
               r.mem_write_value = shadow_regs[shadow_addr.rd];
            end
            shadow_addr.valid = shadow_store.valid;
            if (shadow_store.valid) begin
               addr_sum = shadow_store.a + shadow_store.b;
               shadow_addr.rd   = shadow_store.rd;
               shadow_addr.word = addr_sum[MEM_ADDR_W-1:0];
            end
            shadow_arith.valid = 1'b0;
            shadow_store.valid = 1'b0;
            if (shadow_decode.valid) begin
               if (shadow_decode.op == OP_ST) shadow_store = shadow_decode;
               else shadow_arith = shadow_decode;
            end
            nd = '0;
            if (b.cmd == CMD_STEP) begin
               nd.valid = 1'b1;
               nd.op    = opcode_type'(b.opcode);
               nd.rd    = b.dest_reg;
               nd.a     = shadow_regs[b.src_a_reg];
               nd.b     = (nd.op == OP_ST) ? b.store_offset : shadow_regs[b.src_b_reg];
            end
            shadow_decode    = nd;
            r.queue_overflow = ovf;
         end
         CMD_LOAD_REG: begin
            shadow_regs[b.target_index]        = b.load_value;
            shadow_reg_written[b.target_index] = 1'b1;
         end
         CMD_LOAD_MEM: begin
            shadow_mem[b.target_index]         = b.load_value;
            shadow_mem_written[b.target_index] = 1'b1;
         end
         CMD_READ_REG: begin
            r.read_written = shadow_reg_written[b.target_index];
            r.read_value   = shadow_regs[b.target_index];
         end
         CMD_READ_MEM: begin
            r.read_written = shadow_mem_written[b.target_index];
            r.read_value   = shadow_mem[b.target_index];
         end
         default: begin
         end
      endcase
      r.pipeline_idle = !shadow_decode.valid && !shadow_arith.valid && !shadow_store.valid &&
                        !shadow_pp.valid && !shadow_addr.valid && shadow_wb_q.size() == 0;
      return r;
   endfunction

   function automatic void check_field(string name, logic [DATA_W-1:0] exp,
                                       logic [DATA_W-1:0] act);
      if (act !== exp) begin
         $error("%s: expected %0d, actual %0d", name, exp, act);
         mismatch_count++;
      end
   endfunction

   // Driver: present the next pending beat once the current one is taken
   always @(posedge clock) begin : driver
      cmd_beat_type b;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            b = pending_beats[0];
            pending_beats.delete(0);
            req_bus.valid        <= 1'b1;
            req_bus.cmd          <= b.cmd;
            req_bus.opcode       <= b.opcode;
            req_bus.dest_reg     <= b.dest_reg;
            req_bus.src_a_reg    <= b.src_a_reg;
            req_bus.src_b_reg    <= b.src_b_reg;
            req_bus.store_offset <= b.store_offset;
            req_bus.target_index <= b.target_index;
            req_bus.load_value   <= b.load_value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: check response beats, predict accepted request beats
   always @(posedge clock) begin : monitor
      rsp_type      got;
      rsp_type      exp;
      cmd_beat_type beat;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.reg_write_valid = rsp_bus.reg_write_valid;
            got.reg_write_index = rsp_bus.reg_write_index;
            got.reg_write_value = rsp_bus.reg_write_value;
            got.mem_write_valid = rsp_bus.mem_write_valid;
            got.mem_write_addr  = rsp_bus.mem_write_addr;
            got.mem_write_value = rsp_bus.mem_write_value;
            got.pipeline_idle   = rsp_bus.pipeline_idle;
            got.read_written    = rsp_bus.read_written;
            got.read_value      = rsp_bus.read_value;
            got.queue_overflow  = rsp_bus.queue_overflow;
            if (expected_rsp_q.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatch_count++;
            end else begin
               exp = expected_rsp_q[0];
               expected_rsp_q.delete(0);
               check_field("reg_write_valid", DATA_W'(exp.reg_write_valid),
                           DATA_W'(got.reg_write_valid));
               check_field("reg_write_index", DATA_W'(exp.reg_write_index),
                           DATA_W'(got.reg_write_index));
               check_field("reg_write_value", exp.reg_write_value, got.reg_write_value);
               check_field("mem_write_valid", DATA_W'(exp.mem_write_valid),
                           DATA_W'(got.mem_write_valid));
               check_field("mem_write_addr", DATA_W'(exp.mem_write_addr),
                           DATA_W'(got.mem_write_addr));
               check_field("mem_write_value", exp.mem_write_value, got.mem_write_value);
               check_field("pipeline_idle", DATA_W'(exp.pipeline_idle),
                           DATA_W'(got.pipeline_idle));
               check_field("read_written", DATA_W'(exp.read_written),
                           DATA_W'(got.read_written));
               check_field("read_value", exp.read_value, got.read_value);
               check_field("queue_overflow", DATA_W'(exp.queue_overflow),
                           DATA_W'(got.queue_overflow));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            beat.cmd          = req_bus.cmd;
            beat.opcode       = req_bus.opcode;
            beat.dest_reg     = req_bus.dest_reg;
            beat.src_a_reg    = req_bus.src_a_reg;
            beat.src_b_reg    = req_bus.src_b_reg;
            beat.store_offset = req_bus.store_offset;
            beat.target_index = req_bus.target_index;
            beat.load_value   = req_bus.load_value;
            expected_rsp_q = {expected_rsp_q, predict_response(beat)};
            accepted_count++;
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("toy_alu_store_pipeline_unit: mismatch");
               $finish;
            end
         end
      end
   end

   // Hold the sender until every beat is taken and every response is back
   task automatic wait_drained();
      @(negedge clock);
      while (accepted_count != queued_count || expected_rsp_q.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      cmd_beat_type b;
      int           w;
      int           phase_send [NUM_PHASES];
      int           phase_stall [NUM_PHASES];
      phase_send  = '{0, 87, 0, 27};
      phase_stall = '{0, 0, 87, 27};

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = '0;
      req_bus.opcode       = '0;
      req_bus.dest_reg     = '0;
      req_bus.src_a_reg    = '0;
      req_bus.src_b_reg    = '0;
      req_bus.store_offset = '0;
      req_bus.target_index = '0;
      req_bus.load_value   = '0;
      rsp_bus.ready        = 1'b0;

      for (int i = 0; i < NUM_REGS; i++) begin
         shadow_regs[i]        = REG_RESET_VALUE;
         shadow_reg_written[i] = 1'b0;
      end
      for (int i = 0; i < MEM_WORDS; i++) begin
         shadow_mem[i]         = MEM_RESET_VALUE;
         shadow_mem_written[i] = 1'b0;
      end
      shadow_decode = '0;
      shadow_arith  = '0;
      shadow_store  = '0;
      shadow_pp     = '0;
      shadow_addr   = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      // Directed: unwritten reads, load/read extremes, reserved commands, every opcode
      queue_beat(make_beat(CMD_READ_REG, OP_ADD, 0, 0, 0, 0, 0, 0));
      queue_beat(make_beat(CMD_READ_MEM, OP_ADD, 0, 0, 0, 0, 15, 0));
      queue_beat(make_beat(CMD_LOAD_REG, OP_ADD, 0, 0, 0, 0, 0, 0));
      queue_beat(make_beat(CMD_LOAD_REG, OP_ST, 15, 15, 15, 255, 15, 255));
      queue_beat(make_beat(CMD_LOAD_REG, OP_ADD, 0, 0, 0, 0, 7, 128));
      queue_beat(make_beat(CMD_LOAD_MEM, OP_ADD, 0, 0, 0, 0, 15, 0));
      queue_beat(make_beat(CMD_LOAD_MEM, OP_ADD, 0, 0, 0, 0, 0, 255));
      queue_beat(make_beat(CMD_READ_REG, OP_ADD, 0, 0, 0, 0, 15, 0));
      queue_beat(make_beat(CMD_READ_MEM, OP_ADD, 0, 0, 0, 0, 0, 0));
      queue_beat(make_beat(CMD_RESERVED_A, OP_MUL, 3, 3, 3, 3, 3, 3));
      queue_beat(make_beat(CMD_RESERVED_B, OP_ST, 15, 15, 15, 255, 15, 255));
      queue_beat(make_beat(CMD_STEP, OP_ADD, 1, 15, 15, 0, 0, 0));
      queue_beat(make_beat(CMD_STEP, OP_SUB, 2, 0, 15, 0, 0, 0));
      queue_beat(make_beat(CMD_STEP, OP_MUL, 3, 15, 15, 0, 0, 0));
      // ADD right behind MUL: both results land in the queue in the same step
      queue_beat(make_beat(CMD_STEP, OP_ADD, 4, 7, 0, 0, 0, 0));
      queue_beat(make_beat(CMD_STEP, OP_ST, 15, 15, 0, 255, 0, 0));
      // store of the register written by the first ADD step
      queue_beat(make_beat(CMD_STEP, OP_ST, 1, 0, 0, 0, 0, 0));
      for (int i = 0; i < 5; i++)
         queue_beat(make_beat(CMD_BUBBLE, OP_ADD, 0, 0, 0, 0, 0, 0));
      queue_beat(make_beat(CMD_READ_REG, OP_ADD, 0, 0, 0, 0, 3, 0));
      queue_beat(make_beat(CMD_READ_MEM, OP_ADD, 0, 0, 0, 0, 14, 0));
      queue_beat(make_beat(CMD_READ_MEM, OP_ADD, 0, 0, 0, 0, 0, 0));
      queued_count += pending_beats.size();
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_stall[p];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            b.opcode       = OP_W'($urandom);
            b.dest_reg     = REG_IDX_W'($urandom);
            b.src_a_reg    = REG_IDX_W'($urandom);
            b.src_b_reg    = REG_IDX_W'($urandom);
            b.store_offset = DATA_W'($urandom);
            b.target_index = REG_IDX_W'($urandom);
            b.load_value   = DATA_W'($urandom);
            w = $urandom_range(99);
            if (w < 55) b.cmd = CMD_STEP;
            else if (w < 70) b.cmd = CMD_BUBBLE;
            else if (w < 78) b.cmd = CMD_LOAD_REG;
            else if (w < 84) b.cmd = CMD_LOAD_MEM;
            else if (w < 91) b.cmd = CMD_READ_REG;
            else if (w < 97) b.cmd = CMD_READ_MEM;
            else b.cmd = $urandom_range(1) ? CMD_RESERVED_A : CMD_RESERVED_B;
            queue_beat(b);
         end
         queued_count += RANDOM_PER_PHASE;
         wait_drained();
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      if (expected_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("toy_alu_store_pipeline_unit: match");
      end else begin
         $display("toy_alu_store_pipeline_unit: mismatch");
      end
      $finish;
   end

endmodule
